FILE: hdl/rpcf_pkg.sv
// Shared types and constants for the raster peak clip filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpcf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 16;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);      // column index
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);     // row index
    localparam int INROW_BITS = $clog2(MAX_HEIGHT + 1); // input row, can reach the height
    localparam int WREG_BITS  = 11;                     // frame_width register width
    localparam int HREG_BITS  = 13;                     // frame_height register width
    localparam int CFG_BITS   = 13;                     // widest register

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Broadcast to every cell of the line
    typedef struct packed {
        logic   shift_orig;
        logic   shift_proc;
        pixel_t new_orig;
        pixel_t new_proc;
    } line_ctrl_t;

    // Which of the four neighbours lie inside the frame
    typedef struct packed {
        logic up;
        logic right;
        logic down;
        logic left;
    } nbr_present_t;

endpackage

`default_nettype wire

FILE: hdl/rpcf_cell.sv
// One column cell of the line: holds an original and a processed pixel.
// Depends on rpcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpcf_cell (
    input  wire logic                aclk,
    input  wire rpcf_pkg::line_ctrl_t ctrl,
    input  wire logic                tail,     // this cell is the last active column
    input  wire rpcf_pkg::pixel_t    nbr_orig, // from the cell to the right
    input  wire rpcf_pkg::pixel_t    nbr_proc,
    output rpcf_pkg::pixel_t         orig,
    output rpcf_pkg::pixel_t         proc
);
    import rpcf_pkg::*;

    pixel_t orig_reg;
    pixel_t proc_reg;

    // the tail cell takes the fresh pixel, the rest move one column towards cell 0
    always_ff @(posedge aclk) begin
        if (ctrl.shift_orig) begin
            orig_reg <= tail ? ctrl.new_orig : nbr_orig;
        end
        if (ctrl.shift_proc) begin
            proc_reg <= tail ? ctrl.new_proc : nbr_proc;
        end
    end

    assign orig = orig_reg;
    assign proc = proc_reg;

endmodule

`default_nettype wire

FILE: hdl/rpcf_clip.sv
// Neighbour compare: clips a strict local peak to its largest in-frame neighbour.
// Depends on rpcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpcf_clip (
    input  wire rpcf_pkg::pixel_t     centre,
    input  wire rpcf_pkg::pixel_t     up,
    input  wire rpcf_pkg::pixel_t     right,
    input  wire rpcf_pkg::pixel_t     down,
    input  wire rpcf_pkg::pixel_t     left,
    input  wire rpcf_pkg::nbr_present_t present,
    output rpcf_pkg::pixel_t          result
);
    import rpcf_pkg::*;

    pixel_t up_m, right_m, down_m, left_m;
    pixel_t max_a, max_b, best;
    logic   peak;

    // absent neighbours count as 0 for the max and never block a peak
    always_comb begin
        up_m    = present.up    ? up    : '0;
        right_m = present.right ? right : '0;
        down_m  = present.down  ? down  : '0;
        left_m  = present.left  ? left  : '0;
        max_a   = (up_m > right_m) ? up_m : right_m;
        max_b   = (down_m > left_m) ? down_m : left_m;
        best    = (max_a > max_b) ? max_a : max_b;
        peak    = (!present.up    || (centre > up))    &&
                  (!present.right || (centre > right)) &&
                  (!present.down  || (centre > down))  &&
                  (!present.left  || (centre > left));
        result  = peak ? best : centre;
    end

endmodule

`default_nettype wire

FILE: hdl/raster_peak_clip_filter_core.sv
// Top level of the raster peak clip filter: counters, line of cells, output register.
// Depends on rpcf_pkg, rpcf_cell and rpcf_clip.
`timescale 1ns / 1ps
`default_nettype none

// Hot-pixel clip over a raster stream. Pixels enter in raster order and leave in
// raster order one row late: pixel (r,c) leaves when pixel (r+1,c) is transferred in,
// and the last row is drained by flush transfers (tuser = 1), one pixel each.
// A pixel strictly above all its in-frame 4-neighbours (up and left already
// processed, right and down original) is replaced by the largest of them; a 1x1
// frame gives 0. One transfer is taken every clock unless the output register stalls;
// that register is the only delay; a result appears in the cycle after its transfer.
// The two row buffers are a chain of MAX_WIDTH cells that shifts one column per
// emitted or stored pixel, new pixels entering at the last active column.
// Writing frame_width or frame_height restarts the frame; a partial frame is lost.
module raster_peak_clip_filter_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // [15:0] pixel_in
    input  wire logic                          s_axis_tuser,  // [0] req_type
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [15:0] pixel_out
    output logic                               m_axis_tlast,  // row_end
    output logic                               m_axis_tuser,  // [0] frame_end
    // configuration writes
    input  wire logic                          cfg_wvalid,
    output logic                               cfg_wready,
    input  wire logic                          cfg_windex,
    input  wire logic [rpcf_pkg::CFG_BITS-1:0] cfg_wdata
);
    import rpcf_pkg::*;

    // configuration, kept as last column / last row
    logic [COL_BITS-1:0]   wlast_reg, wlast_next;
    logic [ROW_BITS-1:0]   hlast_reg, hlast_next;
    logic                  restart;

    // positions
    logic [COL_BITS-1:0]   in_col_reg, in_col_next;
    logic [INROW_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_BITS-1:0]   out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]   out_row_reg, out_row_next;
    pixel_t                left_reg, left_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    pixel_t                m_pix_reg;
    logic                  m_row_end_reg;
    logic                  m_frame_end_reg;

    logic                  s_fire, cfg_fire;
    logic                  pix_req, draining, store, emit;
    logic                  last_col, last_row;
    pixel_t                clip_val;
    nbr_present_t          present;
    line_ctrl_t            ctrl;

    logic [WREG_BITS-1:0]  w_raw;
    logic [HREG_BITS-1:0]  h_raw;

    pixel_t                orig_tap [MAX_WIDTH];
    pixel_t                proc_tap [MAX_WIDTH];
    logic [MAX_WIDTH-1:0]  tail;

    assign cfg_wready    = 1'b1;
    assign cfg_fire      = cfg_wvalid && cfg_wready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign pix_req  = !s_axis_tuser;
    assign draining = (in_row_reg > INROW_BITS'(hlast_reg));
    assign store    = pix_req && !draining;
    assign emit     = pix_req ? (!draining && (in_row_reg != '0)) : draining;
    assign last_col = (out_col_reg == wlast_reg);
    assign last_row = (out_row_reg == hlast_reg);

    // register writes, saturated to 1..max
    assign w_raw = cfg_wdata[WREG_BITS-1:0];
    assign h_raw = cfg_wdata[HREG_BITS-1:0];

    always_comb begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        restart    = 1'b0;
        if (cfg_fire) begin
            unique case (cfg_reg_t'(cfg_windex))
                REG_FRAME_WIDTH: begin
                    restart = 1'b1;
                    if (w_raw == '0) begin
                        wlast_next = '0;
                    end else if (w_raw > WREG_BITS'(MAX_WIDTH)) begin
                        wlast_next = COL_BITS'(MAX_WIDTH - 1);
                    end else begin
                        wlast_next = COL_BITS'(w_raw - 1'b1);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    restart = 1'b1;
                    if (h_raw == '0) begin
                        hlast_next = '0;
                    end else if (h_raw > HREG_BITS'(MAX_HEIGHT)) begin
                        hlast_next = ROW_BITS'(MAX_HEIGHT - 1);
                    end else begin
                        hlast_next = ROW_BITS'(h_raw - 1'b1);
                    end
                end
            endcase
        end
    end

    // neighbour compare on the head of the line
    assign present.up    = (out_row_reg != '0);
    assign present.right = !last_col;
    assign present.down  = pix_req;
    assign present.left  = (out_col_reg != '0);

    rpcf_clip u_clip (
        .centre  (orig_tap[0]),
        .up      (proc_tap[0]),
        .right   (orig_tap[1]),
        .down    (s_axis_tdata),
        .left    (left_reg),
        .present (present),
        .result  (clip_val)
    );

    // the original line also moves on drain so the next column reaches cell 0
    assign ctrl.shift_orig = s_fire && (store || emit);
    assign ctrl.shift_proc = s_fire && emit;
    assign ctrl.new_orig   = s_axis_tdata;
    assign ctrl.new_proc   = clip_val;

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_line
        assign tail[k] = (wlast_reg == COL_BITS'(k));
        if (k == MAX_WIDTH - 1) begin : g_end
            rpcf_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .tail     (tail[k]),
                .nbr_orig (ctrl.new_orig),
                .nbr_proc (ctrl.new_proc),
                .orig     (orig_tap[k]),
                .proc     (proc_tap[k])
            );
        end else begin : g_mid
            rpcf_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .tail     (tail[k]),
                .nbr_orig (orig_tap[k+1]),
                .nbr_proc (proc_tap[k+1]),
                .orig     (orig_tap[k]),
                .proc     (proc_tap[k])
            );
        end
    end

    // position counters
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        left_next    = left_reg;
        if (restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            left_next    = '0;
        end else if (s_fire) begin
            if (store) begin
                if (in_col_reg == wlast_reg) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end else begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (emit) begin
                left_next = clip_val;
                if (last_col) begin
                    out_col_next = '0;
                    if (last_row) begin
                        // frame done: everything back to the top-left corner
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_row_next = '0;
                        left_next    = '0;
                    end else begin
                        out_row_next = out_row_reg + 1'b1;
                    end
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    assign m_valid_next = (s_fire && emit) || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg   <= COL_BITS'(MAX_WIDTH - 1);
            hlast_reg   <= ROW_BITS'(MAX_HEIGHT - 1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wlast_reg   <= wlast_next;
            hlast_reg   <= hlast_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            m_pix_reg       <= clip_val;
            m_row_end_reg   <= last_col;
            m_frame_end_reg <= last_col && last_row;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_pix_reg;
    assign m_axis_tlast  = m_row_end_reg;
    assign m_axis_tuser  = m_frame_end_reg;

endmodule

`default_nettype wire

FILE: dv/tb_raster_peak_clip_filter_core.sv
// Self-checking testbench for raster_peak_clip_filter_core: directed and random frames,
// bursty input, stalling output, every result checked against an in-bench clip predictor.
// Depends on rpcf_pkg and raster_peak_clip_filter_core.
`timescale 1ns / 1ps

module tb_raster_peak_clip_filter_core;

    import rpcf_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE = 4;          // quiet cycles after the last input before a register write
    localparam int TAIL = 8;
    localparam int STALL_LIMIT = 2000;  // cycles with no transfer on any channel
    localparam int RUN_CAP = 1000000;
    localparam int RAND_ITEMS = 600;
    localparam int PRINT_CAP = 40;
    localparam int BIG_CUT = 32;        // pixels sent into a widest or tallest frame before it is dropped

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef logic [CFG_BITS-1:0] cfg_word_t;

    typedef enum logic [1:0] {
        ENT_XFER,
        ENT_REG,
        ENT_DRAIN
    } ent_kind_t;

    typedef struct {
        ent_kind_t kind;
        logic      req;
        pixel_t    px;
        cfg_reg_t  idx;
        cfg_word_t val;
    } feed_t;

    typedef struct {
        pixel_t px;
        logic   row_end;
        logic   frame_end;
    } clip_res_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_axis_tvalid = 1'b0;
    wire logic s_axis_tready;
    pixel_t    s_axis_tdata = '0;
    logic      s_axis_tuser = REQ_PIXEL;
    wire logic m_axis_tvalid;
    logic      m_axis_tready = 1'b0;
    wire logic [15:0] m_axis_tdata;
    wire logic m_axis_tlast;
    wire logic m_axis_tuser;
    logic      cfg_wvalid = 1'b0;
    wire logic cfg_wready;
    cfg_reg_t  cfg_windex = REG_FRAME_WIDTH;
    cfg_word_t cfg_wdata = '0;

    raster_peak_clip_filter_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wvalid    (cfg_wvalid),
        .cfg_wready    (cfg_wready),
        .cfg_windex    (cfg_windex),
        .cfg_wdata     (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------------------------------------------------------- clip predictor
    pixel_t      orig_row [MAX_WIDTH];
    pixel_t      proc_row [MAX_WIDTH];
    pixel_t      left_px = '0;
    int unsigned in_c = 0, in_r = 0, out_c = 0, out_r = 0;
    int unsigned fw = MAX_WIDTH, fh = MAX_HEIGHT;

    clip_res_t pix_due_q [$];
    feed_t     feed_q [$];
    int        err_cnt = 0;

    function automatic void clip_restart();
        left_px = '0;
        in_c = 0;
        in_r = 0;
        out_c = 0;
        out_r = 0;
    endfunction

    // Clip pixel (out_r, out_c) against its neighbours and queue it for the output
    function automatic void clip_emit(bit has_down, pixel_t down);
        int unsigned c;
        pixel_t      centre, best, val;
        pixel_t      nb [4];
        bit          here [4];
        bit          peak;
        bit          last_col, last_row;
        clip_res_t   r;
        c = out_c;
        centre = orig_row[c];
        here[0] = (out_r > 0);
        nb[0] = proc_row[c];
        here[1] = (c + 1 < fw);
        nb[1] = here[1] ? orig_row[c + 1] : '0;
        here[2] = has_down;
        nb[2] = down;
        here[3] = (c > 0);
        nb[3] = left_px;
        peak = 1'b1;
        best = '0;
        for (int k = 0; k < 4; k++) begin
            if (here[k]) begin
                if (centre > nb[k]) begin
                    if (nb[k] > best)
                        best = nb[k];
                end else begin
                    peak = 1'b0;
                end
            end
        end
        val = peak ? best : centre;
        proc_row[c] = val;
        left_px = val;
        last_col = (out_c + 1 >= fw);
        last_row = (out_r + 1 >= fh);
        r.px = val;
        r.row_end = last_col;
        r.frame_end = last_col && last_row;
        pix_due_q.push_back(r);
        if (last_col) begin
            out_c = 0;
            if (last_row)
                clip_restart();
            else
                out_r++;
        end else begin
            out_c++;
        end
    endfunction

    // One accepted input transfer; returns 1 when it produces a result
    function automatic bit clip_accept(logic req, pixel_t px);
        bit made;
        made = 1'b0;
        if (req == REQ_FLUSH) begin
            if (in_r >= fh) begin
                clip_emit(1'b0, '0);
                made = 1'b1;
            end
        end else if (in_r < fh) begin
            if (in_r > 0) begin
                clip_emit(1'b1, px);
                made = 1'b1;
            end
            orig_row[in_c] = px;
            if (in_c + 1 >= fw) begin
                in_c = 0;
                in_r++;
            end else begin
                in_c++;
            end
        end
        return made;
    endfunction

    function automatic void clip_set_reg(cfg_reg_t idx, cfg_word_t val);
        int unsigned v;
        if (idx == REG_FRAME_WIDTH) begin
            v = val[WREG_BITS-1:0];
            if (v < 1) v = 1;
            if (v > MAX_WIDTH) v = MAX_WIDTH;
            fw = v;
        end else begin
            v = val[HREG_BITS-1:0];
            if (v < 1) v = 1;
            if (v > MAX_HEIGHT) v = MAX_HEIGHT;
            fh = v;
        end
        clip_restart();
    endfunction

    task automatic report_mismatch(input string what);
        if (err_cnt < PRINT_CAP)
            $display("%0t ns: MISMATCH %s", $time, what);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------- stimulus helpers
    function automatic void add_px(pixel_t px);
        feed_t e;
        e.kind = ENT_XFER;
        e.req = REQ_PIXEL;
        e.px = px;
        e.idx = REG_FRAME_WIDTH;
        e.val = '0;
        feed_q.push_back(e);
    endfunction

    function automatic void add_flush();
        feed_t e;
        e.kind = ENT_XFER;
        e.req = REQ_FLUSH;
        e.px = pixel_t'($urandom);     // don't-care content
        e.idx = REG_FRAME_WIDTH;
        e.val = '0;
        feed_q.push_back(e);
    endfunction

    function automatic void add_reg(cfg_reg_t idx, cfg_word_t val);
        feed_t e;
        e.kind = ENT_REG;
        e.req = REQ_PIXEL;
        e.px = '0;
        e.idx = idx;
        e.val = val;
        feed_q.push_back(e);
    endfunction

    function automatic void add_drain();
        feed_t e;
        e.kind = ENT_DRAIN;
        e.req = REQ_PIXEL;
        e.px = '0;
        e.idx = REG_FRAME_WIDTH;
        e.val = '0;
        feed_q.push_back(e);
    endfunction

    // Pixel content styles: full random, flat with hot spikes, near-ties, rail values
    function automatic pixel_t pick_px(int style, pixel_t base);
        case (style)
            0: return pixel_t'($urandom);
            1: begin
                if ($urandom_range(0, 7) == 0)
                    return pixel_t'($urandom_range(base, 16'hFFFF));
                return base + pixel_t'($urandom_range(0, 3));
            end
            2: return base + pixel_t'($urandom_range(0, 1));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Frame of w x h pixels then w flushes, with stray flushes and ignored pixels mixed in.
    // A cut frame stops part way and is dropped by the next register write.
    function automatic int add_frame(int w, int h, bit cut);
        int     n;
        int     style;
        pixel_t base;
        n = w * h;
        if (cut)
            n = $urandom_range(0, n - 1);
        style = $urandom_range(0, 3);
        base = pixel_t'($urandom_range(0, 16'hF000));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0)
                add_flush();            // nothing to drain yet
            add_px(pick_px(style, base));
        end
        if (cut)
            return n;
        for (int j = 0; j < w; j++) begin
            if ($urandom_range(0, 9) == 0)
                add_px(pick_px(style, base));   // ignored while the last row drains
            add_flush();
        end
        if ($urandom_range(0, 7) == 0)
            add_flush();                // frame already closed
        return n + w;
    endfunction

    // ---------------------------------------------------------------- driver
    int owed_px = 0;
    int quiet_in = 0;
    int gap_left = 0;
    int burst_left = 0;

    always @(posedge aclk) begin
        feed_t ent;
        logic  s_take, c_take, hold_s, hold_c, load_s, load_c;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            cfg_wvalid <= 1'b0;
        end else begin
            s_take = s_axis_tvalid && s_axis_tready;
            c_take = cfg_wvalid && cfg_wready;
            if (m_axis_tvalid && m_axis_tready)
                owed_px--;
            if (s_take && clip_accept(s_axis_tuser, s_axis_tdata))
                owed_px++;
            if (c_take)
                clip_set_reg(cfg_windex, cfg_wdata);
            quiet_in = s_take ? 0 : quiet_in + 1;
            hold_s = s_axis_tvalid && !s_take;
            hold_c = cfg_wvalid && !c_take;
            load_s = 1'b0;
            load_c = 1'b0;
            if (!hold_s && !hold_c && feed_q.size() > 0) begin
                if (feed_q[0].kind == ENT_XFER) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        ent = feed_q.pop_front();
                        load_s = 1'b1;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = ($urandom_range(0, 4) == 0) ?
                                         $urandom_range(50, 200) : $urandom_range(1, 12);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                end else if (owed_px <= 0 && quiet_in >= SETTLE) begin
                    // block idle: register write or plain pause
                    ent = feed_q.pop_front();
                    load_c = (ent.kind == ENT_REG);
                end
            end
            s_axis_tvalid <= hold_s || load_s;
            if (load_s) begin
                s_axis_tdata <= ent.px;
                s_axis_tuser <= ent.req;
            end
            cfg_wvalid <= hold_c || load_c;
            if (load_c) begin
                cfg_windex <= ent.idx;
                cfg_wdata <= ent.val;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    always @(posedge aclk) begin
        clip_res_t want;
        logic      rdy;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pix_due_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with none expected", m_axis_tdata));
                end else begin
                    want = pix_due_q.pop_front();
                    if (m_axis_tdata !== want.px)
                        report_mismatch($sformatf("pixel_out %h, want %h",
                                                  m_axis_tdata, want.px));
                    if (m_axis_tlast !== want.row_end)
                        report_mismatch($sformatf("row_end %b, want %b",
                                                  m_axis_tlast, want.row_end));
                    if (m_axis_tuser !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, want %b",
                                                  m_axis_tuser, want.frame_end));
                end
            end
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(20, 300);
            end else begin
                stall_span--;
            end
            stall_tick++;
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (stall_tick % 5) != 0;
                default: rdy = (stall_tick % 16) < 4;
            endcase
            m_axis_tready <= rdy;
        end
    end

    // ---------------------------------------------------------------- watchdog
    initial begin : watchdog
        int idle;
        int cycles;
        idle = 0;
        cycles = 0;
        while (idle < STALL_LIMIT && cycles < RUN_CAP) begin
            @(posedge aclk);
            cycles++;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_wvalid && cfg_wready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_raster_peak_clip_filter_core: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    initial begin : stimulus
        int        rand_items;
        int        phase;
        int        w, h, nfr;
        cfg_word_t wv, hv;

        // reset geometry: first-row pixels give nothing, flush with nothing to drain
        add_px(16'h0000);
        add_px(16'hFFFF);
        add_px(16'h1234);
        add_flush();
        // zero writes read as 1; restart drops the partial frame; 1x1 frame clips to 0
        add_reg(REG_FRAME_WIDTH, '0);
        add_reg(REG_FRAME_HEIGHT, '0);
        add_px(16'hFFFF);
        add_px(16'h0007);
        add_flush();
        add_flush();
        // 3x2 frame with peaks on both rows, one pixel arriving mid-drain
        add_reg(REG_FRAME_WIDTH, 3);
        add_reg(REG_FRAME_HEIGHT, 2);
        add_px(16'd10);
        add_px(16'hFFFF);
        add_px(16'd10);
        add_px(16'd0);
        add_px(16'd20);
        add_px(16'hFFFF);
        add_flush();
        add_px(16'h5555);
        add_flush();
        add_flush();
        add_flush();
        add_drain();

        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            if (phase == 3) begin
                // widest rows, value above range saturates to the maximum; first row cut short
                add_reg(REG_FRAME_WIDTH, 13'h07FF);
                add_reg(REG_FRAME_HEIGHT, 2);
                for (int i = 0; i < BIG_CUT; i++)
                    add_px(pixel_t'($urandom));
                rand_items += BIG_CUT;
            end else if (phase == 7) begin
                // tallest frame, cut short; width write with spare upper bits set
                add_reg(REG_FRAME_HEIGHT, 13'h1FFF);
                add_reg(REG_FRAME_WIDTH, 13'h1801);
                for (int i = 0; i < BIG_CUT; i++)
                    add_px(pixel_t'($urandom));
                rand_items += BIG_CUT;
            end else begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                wv = cfg_word_t'(w) | (cfg_word_t'($urandom_range(0, 3)) << WREG_BITS);
                hv = cfg_word_t'(h);
                if ($urandom_range(0, 1)) begin
                    add_reg(REG_FRAME_WIDTH, wv);
                    add_reg(REG_FRAME_HEIGHT, hv);
                end else begin
                    add_reg(REG_FRAME_HEIGHT, hv);
                    add_reg(REG_FRAME_WIDTH, wv);
                end
                nfr = $urandom_range(1, 3);
                for (int f = 0; f < nfr; f++)
                    rand_items += add_frame(w, h,
                                            (f == nfr - 1) && ($urandom_range(0, 5) == 0));
            end
            if ($urandom_range(0, 3) == 0)
                add_drain();
            phase++;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        wait (feed_q.size() == 0 && !s_axis_tvalid && !cfg_wvalid);
        wait (pix_due_q.size() == 0);
        repeat (TAIL) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb_raster_peak_clip_filter_core: done, clean");
        else
            $display("tb_raster_peak_clip_filter_core: done, errors");
        $finish;
    end

endmodule
